// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker module
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while reset is held
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/mhpq_pkg.sv =====
// types and codes for the max-heap priority queue
// no dependencies
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int KEY_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    // operation codes
    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] key_in;
    } t_in;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic [STAT_W-1:0]       status;
        logic [CNT_W-1:0]        count;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RM_LOAD,
        S_DN_READ,
        S_DN_CMP,
        S_UP_READ,
        S_UP_CMP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic start_ins;
        logic rd_root;
        logic rm_load;
        logic up_read;
        logic up_step;
        logic dn_read;
        logic dn_step;
        logic write_key;
        logic err_empty;
        logic err_full;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic no_child;
        logic parent_less;
        logic child_greater;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/max_heap_priority_queue.sv =====
// Bounded binary max-heap of signed 32-bit keys.
// Input channel (i_in_valid / o_in_ready / i_in_data): func selects insert of
// key_in or removal of the largest key. Output channel (o_out_valid /
// i_out_ready / o_out_data): one result per item with the removed key (zero
// on insert or error), a status and the count held afterwards.
// One item is worked at a time. A key moves at most log2(CAPACITY) heap
// levels; each level costs one registered read of the storage and a
// compare-and-write. Errors go straight to the result.
// A new item is taken the cycle after its predecessor's result is loaded
// into the output register, even while that result is still waiting.
// If the receiver stalls with a result already waiting, the next result holds
// in the sequencer until the output register frees; nothing is dropped.
// Reset empties the heap (count zero) and clears the result valid; storage
// contents are not cleared and need no sweep.
// depends on mhpq_pkg, mhpq_ctrl, mhpq_datapath
`timescale 1ns / 1ps

module max_heap_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mhpq_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mhpq_pkg::t_out o_out_data
);
    import mhpq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mhpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/mhpq_datapath.sv =====
// heap storage, position and fill registers, compare logic, result register
// depends on mhpq_pkg
`timescale 1ns / 1ps

module mhpq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mhpq_pkg::t_in    i_in_data,
    input  mhpq_pkg::t_dp_cmd i_cmd,
    output mhpq_pkg::t_dp_sts o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mhpq_pkg::t_out   o_out_data
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = AW + 2;

    logic signed [KEY_W-1:0] r_mem [CAPACITY];

    logic                    r_func;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_key_out;
    logic [STAT_W-1:0]       r_status;
    logic [FW-1:0]           r_fill;
    logic [AW-1:0]           r_pos;
    logic signed [KEY_W-1:0] r_rd_a;
    logic signed [KEY_W-1:0] r_rd_b;
    logic                    r_b_ok;
    logic                    r_out_valid;
    t_out                    r_out;

    logic [CW-1:0]           w_child_l;
    logic [CW-1:0]           w_child_r;
    logic [CW-1:0]           w_fill_ext;
    logic [AW-1:0]           w_pos_m1;
    logic [AW-1:0]           w_parent;
    logic [FW-1:0]           w_last;
    logic [AW-1:0]           w_addr_a;
    logic [AW-1:0]           w_addr_b;
    logic                    w_right;
    logic signed [KEY_W-1:0] w_chosen;
    logic [CW-1:0]           w_chosen_pos;
    logic                    w_we;
    logic signed [KEY_W-1:0] w_wdata;
    logic [FW+CNT_W-1:0]     w_cnt_ext;

    assign w_child_l  = {1'b0, r_pos, 1'b0} + CW'(1);
    assign w_child_r  = {1'b0, r_pos, 1'b0} + CW'(2);
    assign w_fill_ext = {{(CW-FW){1'b0}}, r_fill};
    assign w_pos_m1   = r_pos - AW'(1);
    assign w_parent   = w_pos_m1 >> 1;
    assign w_last     = r_fill - FW'(1);

    // left child wins a tie
    assign w_right      = r_b_ok && (r_rd_a < r_rd_b);
    assign w_chosen     = w_right ? r_rd_b : r_rd_a;
    assign w_chosen_pos = w_right ? w_child_r : w_child_l;

    always_comb begin
        w_addr_a = '0;
        w_addr_b = '0;
        if (i_cmd.rd_root) begin
            w_addr_b = w_last[AW-1:0];
        end else if (i_cmd.up_read) begin
            w_addr_a = w_parent;
        end else if (i_cmd.dn_read) begin
            w_addr_a = w_child_l[AW-1:0];
            w_addr_b = w_child_r[AW-1:0];
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_key;
        if (i_cmd.up_step) begin
            w_we    = 1'b1;
            w_wdata = r_rd_a;
        end else if (i_cmd.dn_step) begin
            w_we    = 1'b1;
            w_wdata = w_chosen;
        end else if (i_cmd.write_key) begin
            w_we    = 1'b1;
            w_wdata = r_key;
        end
    end

    // storage: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= w_wdata;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func    <= i_in_data.func;
            r_key     <= i_in_data.key_in;
            r_key_out <= '0;
            r_status  <= ST_OK;
        end
        if (i_cmd.err_empty) begin
            r_status <= ST_EMPTY;
        end
        if (i_cmd.err_full) begin
            r_status <= ST_FULL;
        end
        if (i_cmd.start_ins) begin
            r_pos <= r_fill[AW-1:0];
        end
        if (i_cmd.rm_load) begin
            r_key_out <= r_rd_a;
            r_key     <= r_rd_b;
            r_pos     <= '0;
        end
        if (i_cmd.dn_read) begin
            r_b_ok <= w_child_r < w_fill_ext;
        end
        if (i_cmd.up_step) begin
            r_pos <= w_parent;
        end
        if (i_cmd.dn_step) begin
            r_pos <= w_chosen_pos[AW-1:0];
        end
        if (i_cmd.load_out) begin
            r_out.key_out <= r_key_out;
            r_out.status  <= r_status;
            r_out.count   <= w_cnt_ext[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_ins) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_cmd.rm_load) begin
                r_fill <= w_last;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_cnt_ext = {{CNT_W{1'b0}}, r_fill};

    assign o_sts.is_remove     = r_func == FN_REMOVE;
    assign o_sts.full          = r_fill == FW'(CAPACITY);
    assign o_sts.empty         = r_fill == '0;
    assign o_sts.last_one      = r_fill == FW'(1);
    assign o_sts.pos_zero      = r_pos == '0;
    assign o_sts.no_child      = w_child_l >= w_fill_ext;
    assign o_sts.parent_less   = r_rd_a < r_key;
    assign o_sts.child_greater = r_key < w_chosen;
    assign o_sts.out_free      = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/mhpq_ctrl.sv =====
// sequencer for insert with sift-up and remove with sift-down
// depends on mhpq_pkg
`timescale 1ns / 1ps

module mhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mhpq_pkg::t_dp_sts i_sts,
    output mhpq_pkg::t_dp_cmd o_cmd
);
    import mhpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_remove) begin
                    if (i_sts.empty) begin
                        o_cmd.err_empty = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        o_cmd.rd_root = 1'b1;
                        n_state       = S_RM_LOAD;
                    end
                end else begin
                    if (i_sts.full) begin
                        o_cmd.err_full = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.start_ins = 1'b1;
                        n_state         = S_UP_READ;
                    end
                end
            end
            S_RM_LOAD: begin
                // root goes out, last entry becomes the key to sift down
                o_cmd.rm_load = 1'b1;
                n_state       = i_sts.last_one ? S_DONE : S_DN_READ;
            end
            S_DN_READ: begin
                if (i_sts.no_child) begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.dn_read = 1'b1;
                    n_state       = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_sts.child_greater) begin
                    o_cmd.dn_step = 1'b1;
                    n_state       = S_DN_READ;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_UP_READ: begin
                if (i_sts.pos_zero) begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.up_read = 1'b1;
                    n_state       = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.parent_less) begin
                    o_cmd.up_step = 1'b1;
                    n_state       = S_UP_READ;
                end else begin
                    o_cmd.write_key = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mhpq_checker.sv =====
// port-level checks for the max-heap priority queue, bound to the top level
// depends on mhpq_pkg, assert_macros.svh, max_heap_priority_queue
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhpq_checker #(
    parameter int CAPACITY = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input mhpq_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input mhpq_pkg::t_out o_out_data
);
    import mhpq_pkg::*;

    // stalled result stays put
    `CHK_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // one item at a time: no transfer right after a transfer
    `CHK_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready)

    `CHK_IMPLY(a_err_key_zero, o_out_valid && o_out_data.status != ST_OK, o_out_data.key_out == '0)

    `CHK_IMPLY(a_empty_count, o_out_valid && o_out_data.status == ST_EMPTY, o_out_data.count == '0)

    `CHK_IMPLY(a_full_count, o_out_valid && o_out_data.status == ST_FULL, o_out_data.count == CNT_W'(CAPACITY))

endmodule

bind max_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);
